// ----- hdl/gtn_pkg.sv -----
// ----------------------------------------------------------------------------
// gtn_pkg
// Shared types, constants and helpers of the geodetic to local NED converter.
// ----------------------------------------------------------------------------
package gtn_pkg;

   typedef struct packed {
      logic signed [30:0] lat_in;
      logic signed [31:0] lon_in;
      logic signed [23:0] alt_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] north_out;
      logic signed [31:0] east_out;
      logic signed [23:0] height_out;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_HOME_LAT = 2'd0,
      CSR_HOME_LON = 2'd1,
      CSR_HOME_ALT = 2'd2
   } csr_index_type;

   localparam logic signed [30:0] EARTH_R_CM   = 31'sd637404900;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
   localparam int                 CORDIC_STEPS = 30;

   localparam logic [31:0] DIVISOR  = 32'd3600000000;
   localparam logic [31:0] HALF_DIV = 32'd1800000000;
   localparam logic [29:0] RECIP_LO = 30'd829128280;
   localparam logic [34:0] DIV_1X   = 35'd3600000000;
   localparam logic [34:0] DIV_2X   = 35'd7200000000;

   localparam int PHASE_LAT  = 6;
   localparam int CORDIC_LAT = CORDIC_STEPS + 2;
   localparam int ECEF_LAT   = 4;
   localparam int ROT_LAT    = 6;
   localparam int PIPE_LAT   = PHASE_LAT + CORDIC_LAT + ECEF_LAT + ROT_LAT;

   function automatic logic [29:0] atan_val(input int unsigned idx);
      logic [29:0] v;
      case (idx)
         0:  v = 30'd536870912;
         1:  v = 30'd316933406;
         2:  v = 30'd167458907;
         3:  v = 30'd85004756;
         4:  v = 30'd42667331;
         5:  v = 30'd21354465;
         6:  v = 30'd10680862;
         7:  v = 30'd5340245;
         8:  v = 30'd2670163;
         9:  v = 30'd1335087;
         10: v = 30'd667544;
         11: v = 30'd333772;
         12: v = 30'd166886;
         13: v = 30'd83443;
         14: v = 30'd41722;
         15: v = 30'd20861;
         16: v = 30'd10430;
         17: v = 30'd5215;
         18: v = 30'd2608;
         19: v = 30'd1304;
         20: v = 30'd652;
         21: v = 30'd326;
         22: v = 30'd163;
         23: v = 30'd81;
         24: v = 30'd41;
         25: v = 30'd20;
         26: v = 30'd10;
         27: v = 30'd5;
         28: v = 30'd3;
         29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
      return (v + 72'sd536870912) >>> 30;
   endfunction

endpackage

// ----- hdl/geodetic_to_local_ned.sv -----
// ----------------------------------------------------------------------------
// geodetic_to_local_ned
// Pipeline of phase, CORDIC, earth-centred and rotation sections, from input
// transfer to result. Throughput: one fix per cycle; the whole
// pipeline holds while a result waits under stall. Reset is synchronous,
// active high: it clears the valid bits and sets the home registers to zero.
// ----------------------------------------------------------------------------
module geodetic_to_local_ned import gtn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int ALIGN_LAT = PHASE_LAT + CORDIC_LAT;

   logic signed [30:0] home_lat_ff;
   logic signed [31:0] home_lon_ff;
   logic signed [23:0] home_alt_ff;
   logic signed [30:0] home_r_ff;
   logic [PIPE_LAT-1:0] valid_ff;

   logic               en;
   logic signed [30:0] r_pt_in, r_pt_d;
   logic signed [24:0] height_diff;
   logic signed [23:0] height_in, height_d;

   logic [31:0]        ph_lat, ph_lon, ph_hlat, ph_hlon;
   logic signed [31:0] sl, cl, so, co, s_hlat, c_hlat, s_hlon, c_hlon;
   logic signed [31:0] px, py, pz, hx, hy, hz;
   logic signed [31:0] north, east;

   assign en        = !valid_ff[PIPE_LAT-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = valid_ff[PIPE_LAT-1];
   assign csr_ready = 1'b1;

   always_comb begin
      r_pt_in     = EARTH_R_CM - 31'(req_data.alt_in);
      height_diff = 25'(req_data.alt_in) - 25'(home_alt_ff);
      if (height_diff > 25'sd8388607) begin
         height_in = 24'sh7FFFFF;
      end else if (height_diff < -25'sd8388608) begin
         height_in = 24'sh800000;
      end else begin
         height_in = height_diff[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_lat_ff <= '0;
         home_lon_ff <= '0;
         home_alt_ff <= '0;
         valid_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HOME_LAT: home_lat_ff <= csr_data[30:0];
               CSR_HOME_LON: home_lon_ff <= csr_data;
               CSR_HOME_ALT: home_alt_ff <= csr_data[23:0];
               default: ;
            endcase
         end
         if (en) begin
            valid_ff <= {valid_ff[PIPE_LAT-2:0], req_valid};
         end
      end
      home_r_ff <= EARTH_R_CM - 31'(home_alt_ff);
   end

   gtn_phase u_ph_lat  (.clock, .en, .deg(32'(req_data.lat_in)), .phase(ph_lat));
   gtn_phase u_ph_lon  (.clock, .en, .deg(req_data.lon_in),      .phase(ph_lon));
   gtn_phase u_ph_hlat (.clock, .en, .deg(32'(home_lat_ff)),     .phase(ph_hlat));
   gtn_phase u_ph_hlon (.clock, .en, .deg(home_lon_ff),          .phase(ph_hlon));

   gtn_cordic u_cs_lat  (.clock, .en, .phase(ph_lat),  .sin_out(sl),     .cos_out(cl));
   gtn_cordic u_cs_lon  (.clock, .en, .phase(ph_lon),  .sin_out(so),     .cos_out(co));
   gtn_cordic u_cs_hlat (.clock, .en, .phase(ph_hlat), .sin_out(s_hlat), .cos_out(c_hlat));
   gtn_cordic u_cs_hlon (.clock, .en, .phase(ph_hlon), .sin_out(s_hlon), .cos_out(c_hlon));

   gtn_delay #(.WIDTH(31), .DEPTH(ALIGN_LAT)) u_r_dly (
      .clock, .en, .data_in(r_pt_in), .data_out(r_pt_d)
   );

   gtn_delay #(.WIDTH(24), .DEPTH(PIPE_LAT)) u_h_dly (
      .clock, .en, .data_in(height_in), .data_out(height_d)
   );

   gtn_ecef u_ecef_pt (
      .clock, .en, .r(r_pt_d), .sl(sl), .cl(cl), .so(so), .co(co),
      .x_out(px), .y_out(py), .z_out(pz)
   );

   gtn_ecef u_ecef_home (
      .clock, .en, .r(home_r_ff), .sl(s_hlat), .cl(c_hlat), .so(s_hlon), .co(c_hlon),
      .x_out(hx), .y_out(hy), .z_out(hz)
   );

   gtn_rotate u_rotate (
      .clock, .en, .px, .py, .pz, .hx, .hy, .hz,
      .s_lat(s_hlat), .c_lat(c_hlat), .s_lon(s_hlon), .c_lon(c_hlon),
      .north, .east
   );

   assign rsp_data.north_out  = north;
   assign rsp_data.east_out   = east;
   assign rsp_data.height_out = height_d;

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transfer did not enter the pipeline");

   a_hold_freezes: assert property (@(posedge clock) disable iff (reset)
      (!en) |=> $stable(valid_ff))
      else $error("pipeline moved while held");

   a_csr_alt: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CSR_HOME_ALT)
      |=> home_alt_ff == $past(csr_data[23:0]))
      else $error("home altitude write lost");
`endif

endmodule

// ----- hdl/gtn_delay.sv -----
// ----------------------------------------------------------------------------
// gtn_delay
// Stall-aware shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module gtn_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= data_in;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign data_out = stage_ff[DEPTH-1];

endmodule

// ----- hdl/gtn_phase.sv -----
// ----------------------------------------------------------------------------
// gtn_phase
// Degrees times 1e7 to a 32 bit turn phase, rounded, by reciprocal multiply.
// ----------------------------------------------------------------------------
module gtn_phase import gtn_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] deg,
   output logic        [31:0] phase
);

   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [31:0] mag1_ff, mag2_ff, mag3_ff, mag4_ff;
   logic [61:0] lo2_ff;
   logic [31:0] q3_ff, q4_ff, q5_ff;
   logic [63:0] pr4_ff;
   logic [34:0] rem5_ff;
   logic [31:0] phase_ff;

   logic [63:0] num_in;
   logic [63:0] rem_in;
   logic [31:0] qc_in;

   always_comb begin
      num_in = {mag4_ff, 32'd0} + {32'd0, HALF_DIV};
      rem_in = num_in - pr4_ff;
      if (rem5_ff >= DIV_2X) begin
         qc_in = q5_ff + 32'd2;
      end else if (rem5_ff >= DIV_1X) begin
         qc_in = q5_ff + 32'd1;
      end else begin
         qc_in = q5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= deg[31];
         mag1_ff  <= deg[31] ? (~deg + 32'd1) : deg;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         lo2_ff   <= mag1_ff * RECIP_LO;
         neg3_ff  <= neg2_ff;
         mag3_ff  <= mag2_ff;
         q3_ff    <= mag2_ff + {2'd0, lo2_ff[61:32]};
         neg4_ff  <= neg3_ff;
         mag4_ff  <= mag3_ff;
         q4_ff    <= q3_ff;
         pr4_ff   <= q3_ff * DIVISOR;
         neg5_ff  <= neg4_ff;
         q5_ff    <= q4_ff;
         rem5_ff  <= rem_in[34:0];
         phase_ff <= neg5_ff ? (~qc_in + 32'd1) : qc_in;
      end
   end

   assign phase = phase_ff;

endmodule

// ----- hdl/gtn_cordic.sv -----
// ----------------------------------------------------------------------------
// gtn_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, Q30 outputs.
// ----------------------------------------------------------------------------
module gtn_cordic import gtn_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic        [31:0] phase,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   localparam int XW = 34;
   localparam int ZW = 34;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd2147483648);

   logic signed [XW-1:0] x_ff   [CORDIC_STEPS+1];
   logic signed [XW-1:0] y_ff   [CORDIC_STEPS+1];
   logic signed [ZW-1:0] z_ff   [CORDIC_STEPS+1];
   logic                 neg_ff [CORDIC_STEPS+1];
   logic signed [31:0]   sin_ff, cos_ff;

   logic signed [ZW-1:0] a_ext, a_fold;
   logic                 fold_neg;
   logic signed [XW-1:0] sin_full, cos_full;

   always_comb begin
      a_ext    = ZW'(signed'(phase));
      a_fold   = a_ext;
      fold_neg = 1'b0;
      if (a_ext > QUARTER) begin
         a_fold   = a_ext - HALF;
         fold_neg = 1'b1;
      end else if (a_ext < -QUARTER) begin
         a_fold   = a_ext + HALF;
         fold_neg = 1'b1;
      end
      sin_full = neg_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      cos_full = neg_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= a_fold;
         neg_ff[0] <= fold_neg;
         sin_ff    <= sin_full[31:0];
         cos_ff    <= cos_full[31:0];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_val(i));
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end
         end
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ----- hdl/gtn_ecef.sv -----
// ----------------------------------------------------------------------------
// gtn_ecef
// Spherical earth-centred coordinates from radius and angle sine/cosine.
// ----------------------------------------------------------------------------
module gtn_ecef import gtn_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [30:0] r,
   input  logic signed [31:0] sl,
   input  logic signed [31:0] cl,
   input  logic signed [31:0] so,
   input  logic signed [31:0] co,
   output logic signed [31:0] x_out,
   output logic signed [31:0] y_out,
   output logic signed [31:0] z_out
);

   logic signed [62:0] pc1_ff, ps1_ff;
   logic signed [31:0] so1_ff, co1_ff, so2_ff, co2_ff;
   logic signed [31:0] u2_ff, z2_ff, z3_ff, z4_ff;
   logic signed [63:0] px3_ff, py3_ff;
   logic signed [31:0] x4_ff, y4_ff;

   logic signed [71:0] u_rnd, z_rnd, x_rnd, y_rnd;

   always_comb begin
      u_rnd = rnd30(72'(pc1_ff));
      z_rnd = rnd30(72'(ps1_ff));
      x_rnd = rnd30(72'(px3_ff));
      y_rnd = rnd30(72'(py3_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc1_ff <= r * cl;
         ps1_ff <= r * sl;
         so1_ff <= so;
         co1_ff <= co;
         u2_ff  <= u_rnd[31:0];
         z2_ff  <= z_rnd[31:0];
         so2_ff <= so1_ff;
         co2_ff <= co1_ff;
         px3_ff <= u2_ff * co2_ff;
         py3_ff <= u2_ff * so2_ff;
         z3_ff  <= z2_ff;
         x4_ff  <= x_rnd[31:0];
         y4_ff  <= y_rnd[31:0];
         z4_ff  <= z3_ff;
      end
   end

   assign x_out = x4_ff;
   assign y_out = y4_ff;
   assign z_out = z4_ff;

endmodule

// ----- hdl/gtn_rotate.sv -----
// ----------------------------------------------------------------------------
// gtn_rotate
// Difference vector rotated into the home frame, rounded and saturated.
// ----------------------------------------------------------------------------
module gtn_rotate import gtn_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] px,
   input  logic signed [31:0] py,
   input  logic signed [31:0] pz,
   input  logic signed [31:0] hx,
   input  logic signed [31:0] hy,
   input  logic signed [31:0] hz,
   input  logic signed [31:0] s_lat,
   input  logic signed [31:0] c_lat,
   input  logic signed [31:0] s_lon,
   input  logic signed [31:0] c_lon,
   output logic signed [31:0] north,
   output logic signed [31:0] east
);

   localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
   localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] s;
      if (v > SAT_HI) begin
         s = SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         s = SAT_LO[31:0];
      end else begin
         s = v[31:0];
      end
      return s;
   endfunction

   logic signed [32:0] dx1_ff, dy1_ff, dz1_ff;
   logic signed [63:0] ma2_ff, mb2_ff;
   logic signed [64:0] e1_2_ff, e2_2_ff, nc2_ff, nc3_ff, nc4_ff;
   logic signed [32:0] dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic signed [31:0] a3_ff, b3_ff;
   logic signed [65:0] esum3_ff;
   logic signed [64:0] na4_ff, nb4_ff;
   logic signed [31:0] east4_ff, east5_ff, east6_ff, north6_ff;
   logic signed [66:0] nsum5_ff;

   logic signed [71:0] a_rnd, b_rnd;

   always_comb begin
      a_rnd = rnd30(72'(ma2_ff));
      b_rnd = rnd30(72'(mb2_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff    <= 33'(px) - 33'(hx);
         dy1_ff    <= 33'(py) - 33'(hy);
         dz1_ff    <= 33'(pz) - 33'(hz);
         ma2_ff    <= s_lat * c_lon;
         mb2_ff    <= s_lat * s_lon;
         e1_2_ff   <= s_lon * dx1_ff;
         e2_2_ff   <= c_lon * dy1_ff;
         nc2_ff    <= c_lat * dz1_ff;
         dx2_ff    <= dx1_ff;
         dy2_ff    <= dy1_ff;
         a3_ff     <= a_rnd[31:0];
         b3_ff     <= b_rnd[31:0];
         esum3_ff  <= 66'(e2_2_ff) - 66'(e1_2_ff);
         dx3_ff    <= dx2_ff;
         dy3_ff    <= dy2_ff;
         nc3_ff    <= nc2_ff;
         na4_ff    <= a3_ff * dx3_ff;
         nb4_ff    <= b3_ff * dy3_ff;
         east4_ff  <= sat32(rnd30(72'(esum3_ff)));
         nc4_ff    <= nc3_ff;
         nsum5_ff  <= 67'(nc4_ff) - 67'(na4_ff) - 67'(nb4_ff);
         east5_ff  <= east4_ff;
         north6_ff <= sat32(rnd30(72'(nsum5_ff)));
         east6_ff  <= east5_ff;
      end
   end

   assign north = north6_ff;
   assign east  = east6_ff;

endmodule

// ----- verif/geodetic_to_local_ned_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geodetic_to_local_ned_tb
// Drives random and corner-case position fixes through the converter under
// several home points. A scoreboard predicts each north/east/height result
// and compares it with the block's output in order, with random idling on
// both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module geodetic_to_local_ned_tb;
   import gtn_pkg::*;

   localparam longint R_CM = 637404900;
   localparam longint GAIN = 652032874;
   localparam int LIMIT = 2000000;

   class ned_scoreboard;
      longint hlat, hlon, halt;
      rsp_type pending[$];
      int errors;

      static function longint rnd(longint v);
         return (v + (64'sd1 << 29)) >>> 30;
      endfunction

      static function longint atan_entry(int i);
         longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1};
         return t[i];
      endfunction

      static function bit [31:0] phase_of(longint d);
         longint unsigned mag, ph;
         mag = (d < 0) ? -d : d;
         ph = ((mag << 32) + 64'd1800000000) / 64'd3600000000;
         if (d < 0) ph = -ph;
         return ph[31:0];
      endfunction

      static function void sincos(bit [31:0] ph, output longint s, output longint c);
         longint a, x, y, z, sx, sy;
         bit neg;
         a = longint'($signed(ph));
         neg = 0;
         if (a > (64'sd1 << 30)) begin
            a -= 64'sd1 << 31; neg = 1;
         end else if (a < -(64'sd1 << 30)) begin
            a += 64'sd1 << 31; neg = 1;
         end
         x = GAIN; y = 0; z = a;
         for (int i = 0; i < 30; i++) begin
            sx = y >>> i; sy = x >>> i;
            if (z >= 0) begin
               x -= sx; y += sy; z -= atan_entry(i);
            end else begin
               x += sx; y -= sy; z += atan_entry(i);
            end
         end
         s = neg ? -y : y;
         c = neg ? -x : x;
      endfunction

      static function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (64'sd1 << (w - 1)) - 1;
         lo = -(64'sd1 << (w - 1));
         return v > hi ? hi : (v < lo ? lo : v);
      endfunction

      function new();
         hlat = 0; hlon = 0; halt = 0; errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, bit [31:0] v);
         case (idx)
            CSR_HOME_LAT: hlat = longint'($signed(v[30:0]));
            CSR_HOME_LON: hlon = longint'($signed(v));
            CSR_HOME_ALT: halt = longint'($signed(v[23:0]));
            default: ;
         endcase
      endfunction

      function void note_fix(req_type f);
         longint sL, cL, sO, cO, sl, cl, so, co, u, hx, hy, hz, px, py, pz;
         longint r, dx, dy, dz, n, e, a;
         rsp_type p;
         sincos(phase_of(hlat), sL, cL);
         sincos(phase_of(hlon), sO, cO);
         sincos(phase_of(longint'(f.lat_in)), sl, cl);
         sincos(phase_of(longint'(f.lon_in)), so, co);
         r = R_CM - halt;
         u = rnd(r * cL); hx = rnd(u * cO); hy = rnd(u * sO); hz = rnd(r * sL);
         a = longint'(f.alt_in);
         r = R_CM - a;
         u = rnd(r * cl); px = rnd(u * co); py = rnd(u * so); pz = rnd(r * sl);
         dx = px - hx; dy = py - hy; dz = pz - hz;
         n = rnd(-rnd(sL * cO) * dx - rnd(sL * sO) * dy + cL * dz);
         e = rnd(-sO * dx + cO * dy);
         p.north_out = 32'(clamp(n, 32));
         p.east_out = 32'(clamp(e, 32));
         p.height_out = 24'(clamp(a - halt, 24));
         pending.push_back(p);
      endfunction

      function void check_result(rsp_type got);
         rsp_type x;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (got.north_out !== x.north_out) begin
            $display("%0t north exp %0d got %0d", $time, x.north_out, got.north_out);
            errors++;
         end
         if (got.east_out !== x.east_out) begin
            $display("%0t east exp %0d got %0d", $time, x.east_out, got.east_out);
            errors++;
         end
         if (got.height_out !== x.height_out) begin
            $display("%0t height exp %0d got %0d", $time, x.height_out, got.height_out);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int send_idle = 0, recv_idle = 0, hold_cycles = 0;
   longint cycle = 0;
   ned_scoreboard board = new();

   geodetic_to_local_ned u_top (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic write_reg(csr_index_type idx, bit [31:0] v);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.set_reg(idx, v);
   endtask

   task automatic set_home(longint la, longint lo, longint al);
      write_reg(CSR_HOME_LAT, 32'(la));
      write_reg(CSR_HOME_LON, 32'(lo));
      write_reg(CSR_HOME_ALT, 32'(al));
   endtask

   task automatic send_fix(req_type f);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_data <= f;
      do @(posedge clock); while (req_stall);
      board.note_fix(f);
   endtask

   task automatic quiesce();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic req_type make_fix(longint la, longint lo, longint al);
      req_type f;
      f.lat_in = 31'(la); f.lon_in = 32'(lo); f.alt_in = 24'(al);
      return f;
   endfunction

   function automatic req_type random_fix();
      req_type f;
      if ($urandom_range(9) == 0) begin
         f.lat_in = 31'($urandom);
         f.lon_in = $urandom;
         f.alt_in = 24'($urandom);
      end else begin
         f.lat_in = 31'($signed($urandom_range(1800000000)) - 900000000);
         f.lon_in = 32'(longint'($urandom_range(3600000000)) - 1800000000);
         f.alt_in = 24'($signed($urandom_range(5100000)) - 100000);
      end
      return f;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_fix(make_fix(0, 0, 0));
      send_fix(make_fix(900000000, 1800000000, 5000000));
      send_fix(make_fix(-900000000, -1800000000, -100000));
      send_fix(make_fix(450000000, 900000000, 1000));
      send_fix(make_fix(-450000000, -900000000, 12345));
      send_fix(make_fix(31'sh3fffffff, 32'sh7fffffff, 24'sh7fffff));
      send_fix(make_fix(31'sh40000000, 32'sh80000000, 24'sh800000));
      send_fix(make_fix(-1, -1, -1));
      quiesce();
      set_home(900000000, 1800000000, 5000000);
      send_fix(make_fix(-900000000, 0, -100000));
      send_fix(make_fix(900000000, 1800000000, 5000000));
      send_fix(make_fix(31'sh40000000, 32'sh80000000, 24'sh800000));
      quiesce();
      set_home(31'sh40000000, 32'sh80000000, 24'sh800000);
      send_fix(make_fix(31'sh3fffffff, 32'sh7fffffff, 24'sh7fffff));
      send_fix(make_fix(0, 0, 0));
      quiesce();
      write_reg(csr_index_type'(2'd3), 32'hdeadbeef);
      set_home(-900000000, -1800000000, -100000);
      send_fix(make_fix(900000000, 1800000000, 5000000));
      quiesce();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 9 : (ph == 1) ? 76 : 0;
         recv_idle = (ph == 0) ? 76 : (ph == 1) ? 9 : 0;
         set_home($signed($urandom_range(1800000000)) - 900000000,
                  longint'($urandom_range(3600000000)) - 1800000000,
                  $signed($urandom_range(5100000)) - 100000);
         for (int i = 0; i < 230; i++) begin
            if (ph == 2 && i == 20) hold_cycles = 300;
            send_fix(random_fix());
         end
         quiesce();
      end
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
